FILE: rtl/hkht_pkg.sv
// Shared constants and register codes for the Hall key hysteresis and travel block.
`default_nettype none

package hkht_pkg;

  // Default sensor resolution
  localparam int unsigned ADC_BITS_DEF = 12;

  // Travel scale: 0..TRAVEL_FULL thousandths
  localparam int unsigned TRAVEL_FULL = 1000;
  localparam int unsigned TRAVEL_W    = 10;

  // Quotient bits produced by the divider; 2047 stands in for any quotient of 2048 or more
  localparam int unsigned QUO_W = 11;

  // Reset levels of the hysteresis thresholds
  localparam int unsigned PRESS_RESET   = 2200;
  localparam int unsigned RELEASE_RESET = 1800;

  // Configuration port geometry
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 3;

  // Result tdata: pressed in bit 0, travel above it, zero padded to 16 bits
  localparam int unsigned OUT_TDATA_W = 16;

  // Register index (byte address / 4)
  typedef enum logic [REG_IDX_W-1:0] {
    REG_PRESS_LEVEL   = 3'd0,
    REG_RELEASE_LEVEL = 3'd1,
    REG_CAL_VALID     = 3'd2,
    REG_REST_READING  = 3'd3,
    REG_FULL_READING  = 3'd4,
    REG_INVERT_TRAVEL = 3'd5,
    REG_DEAD_LOW      = 3'd6,
    REG_DEAD_HIGH     = 3'd7
  } reg_idx_e;

endpackage

`default_nettype wire

FILE: rtl/hall_key_hysteresis_and_travel.sv
// Hall key channel: hysteresis pressed flag and normalized travel with a serial divider.
//
// Each sensor item yields one result item: the hysteresis key state and travel 0..1000.
// The pressed flag is updated when the item is accepted. Travel comes from one shared
// restoring divider that produces one quotient bit per cycle: eleven steps for the
// calibration division, and eleven more for the deadzone rescale when the window is
// active and the travel lies inside it. A finished result sits in the output register
// while the next item is already being worked on. Registers sit at byte address
// 4*index on the APB port and are to be written only while the block is idle; the
// block itself does not enforce this.
`default_nettype none

module hall_key_hysteresis_and_travel
  import hkht_pkg::*;
#(
  parameter int unsigned ADC_BITS = ADC_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Sensor items
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [((ADC_BITS+7)/8)*8-1:0]        s_axis_tdata,  // [ADC_BITS-1:0] sample
  // Result items
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [OUT_TDATA_W-1:0]                    m_axis_tdata,  // [0] pressed, [10:1] travel
  // Configuration
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [APB_ADDR_W-1:0]                paddr,
  input  wire logic [APB_DATA_W-1:0]                pwdata,
  output logic [APB_DATA_W-1:0]                     prdata,
  output logic                                      pready
);

  // Divider widths: operands cover both the sensor span and the travel span
  localparam int unsigned AW = ADC_BITS;
  localparam int unsigned DW = (ADC_BITS > TRAVEL_W) ? ADC_BITS : TRAVEL_W;
  localparam int unsigned NW = DW + QUO_W - 1;

  // Sequencer states
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PREP = 8'b0000_0010,
    S_CHK  = 8'b0000_0100,
    S_DIV1 = 8'b0000_1000,
    S_FIX  = 8'b0001_0000,
    S_WIN  = 8'b0010_0000,
    S_DIV2 = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [AW-1:0]       press_q, release_q, rest_q, full_q;
  logic                cal_valid_q, invert_q;
  logic [TRAVEL_W-1:0] dead_low_q, dead_high_q;

  // Datapath registers
  logic                key_down_q;
  logic [AW-1:0]       sample_q;
  logic [NW-1:0]       rem_q, dsh_q;
  logic [QUO_W-1:0]    quo_q;
  logic [3:0]          cnt_q;
  logic                neg_q, sat_q;
  logic [TRAVEL_W-1:0] tc_q, trav_q;

  // Output register
  logic                m_valid_q, m_pressed_q;
  logic [TRAVEL_W-1:0] m_travel_q;

  logic                s_acc, cfg_wr, out_load;
  logic [AW-1:0]       s_sample;
  reg_idx_e            cfg_idx;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign s_sample      = s_axis_tdata[AW-1:0];
  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign cfg_idx       = reg_idx_e'(paddr[APB_ADDR_W-1:2]);

  // Times 1000 by constant product
  function automatic logic [NW-1:0] mul_full(input logic [DW-1:0] x);
    mul_full = NW'(x) * NW'(TRAVEL_FULL);
  endfunction

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q     <= AW'(PRESS_RESET);
      release_q   <= AW'(RELEASE_RESET);
      cal_valid_q <= 1'b0;
      rest_q      <= '0;
      full_q      <= '1;
      invert_q    <= 1'b0;
      dead_low_q  <= '0;
      dead_high_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PRESS_LEVEL:   press_q     <= pwdata[AW-1:0];
        REG_RELEASE_LEVEL: release_q   <= pwdata[AW-1:0];
        REG_CAL_VALID:     cal_valid_q <= pwdata[0];
        REG_REST_READING:  rest_q      <= pwdata[AW-1:0];
        REG_FULL_READING:  full_q      <= pwdata[AW-1:0];
        REG_INVERT_TRAVEL: invert_q    <= pwdata[0];
        REG_DEAD_LOW:      dead_low_q  <= pwdata[TRAVEL_W-1:0];
        REG_DEAD_HIGH:     dead_high_q <= pwdata[TRAVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_PRESS_LEVEL:   prdata = APB_DATA_W'(press_q);
      REG_RELEASE_LEVEL: prdata = APB_DATA_W'(release_q);
      REG_CAL_VALID:     prdata = APB_DATA_W'(cal_valid_q);
      REG_REST_READING:  prdata = APB_DATA_W'(rest_q);
      REG_FULL_READING:  prdata = APB_DATA_W'(full_q);
      REG_INVERT_TRAVEL: prdata = APB_DATA_W'(invert_q);
      REG_DEAD_LOW:      prdata = APB_DATA_W'(dead_low_q);
      REG_DEAD_HIGH:     prdata = APB_DATA_W'(dead_high_q);
      default:           prdata = '0;
    endcase
  end

  // Hysteresis flag, updated on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_down_q <= 1'b0;
    end else if (s_acc) begin
      if (!key_down_q && (s_sample >= press_q)) begin
        key_down_q <= 1'b1;
      end else if (key_down_q && (s_sample <= release_q)) begin
        key_down_q <= 1'b0;
      end
    end
  end

  // Calibration span and signed operands
  logic          use_cal;
  logic [AW-1:0] rest_sel, full_sel, diff_abs, den_abs;
  logic [AW:0]   diff, den;

  always_comb begin
    use_cal  = cal_valid_q && (rest_q != full_q);
    rest_sel = use_cal ? rest_q : '0;
    full_sel = use_cal ? full_q : '1;
    diff     = {1'b0, sample_q} - {1'b0, rest_sel};
    den      = {1'b0, full_sel} - {1'b0, rest_sel};
    diff_abs = diff[AW] ? AW'(-diff) : diff[AW-1:0];
    den_abs  = den[AW]  ? AW'(-den)  : den[AW-1:0];
  end

  // One restoring step: one quotient bit per cycle
  logic             div_ge;
  logic [QUO_W-1:0] quo_nxt;

  assign div_ge  = (rem_q >= dsh_q);
  assign quo_nxt = {quo_q[QUO_W-2:0], div_ge};

  // Signed travel from the first quotient, inverted when selected, and clamped
  logic [QUO_W-1:0]   mag;
  logic signed [12:0] ts;
  logic [TRAVEL_W-1:0] tc;

  always_comb begin
    mag = sat_q ? '1 : quo_q;
    ts  = neg_q ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    if (invert_q) begin
      ts = $signed(13'(TRAVEL_FULL)) - ts;
    end
    priority if (ts[12]) begin
      tc = '0;
    end else if (ts > $signed(13'(TRAVEL_FULL))) begin
      tc = TRAVEL_W'(TRAVEL_FULL);
    end else begin
      tc = ts[TRAVEL_W-1:0];
    end
  end

  // Deadzone window operands
  logic                win_on;
  logic [TRAVEL_W-1:0] win_num, win_den;

  assign win_on  = (dead_high_q > dead_low_q);
  assign win_num = tc_q - dead_low_q;
  assign win_den = dead_high_q - dead_low_q;

  assign out_load = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_acc) state_d = S_PREP;
      S_PREP: state_d = S_CHK;
      S_CHK:  state_d = S_DIV1;
      S_DIV1: if (cnt_q == 4'd0) state_d = S_FIX;
      S_FIX:  state_d = S_WIN;
      S_WIN: begin
        if (win_on && (tc_q > dead_low_q) && (tc_q < dead_high_q)) begin
          state_d = S_DIV2;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV2: if (cnt_q == 4'd0) state_d = S_DONE;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath: operand setup, shared serial divider, travel shaping
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (s_acc) sample_q <= s_sample;
      end
      S_PREP: begin
        rem_q <= mul_full(DW'(diff_abs));
        dsh_q <= {DW'(den_abs), (QUO_W-1)'(0)};
        neg_q <= diff[AW] ^ den[AW];
      end
      S_CHK: begin
        // quotient of 2048 or more saturates the travel
        sat_q <= ({1'b0, rem_q} >= {dsh_q, 1'b0});
        quo_q <= '0;
        cnt_q <= 4'(QUO_W - 1);
      end
      S_DIV1, S_DIV2: begin
        if (div_ge) rem_q <= rem_q - dsh_q;
        dsh_q <= dsh_q >> 1;
        quo_q <= quo_nxt;
        cnt_q <= cnt_q - 4'd1;
        if ((state_q == S_DIV2) && (cnt_q == 4'd0)) trav_q <= quo_nxt[TRAVEL_W-1:0];
      end
      S_FIX: begin
        tc_q <= tc;
      end
      S_WIN: begin
        if (!win_on) begin
          trav_q <= tc_q;
        end else if (tc_q <= dead_low_q) begin
          trav_q <= '0;
        end else if (tc_q >= dead_high_q) begin
          trav_q <= TRAVEL_W'(TRAVEL_FULL);
        end else begin
          rem_q <= mul_full(DW'(win_num));
          dsh_q <= {DW'(win_den), (QUO_W-1)'(0)};
          quo_q <= '0;
          cnt_q <= 4'(QUO_W - 1);
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_pressed_q <= key_down_q;
      m_travel_q  <= trav_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-TRAVEL_W-1){1'b0}}, m_travel_q, m_pressed_q};

  // Travel never leaves full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[TRAVEL_W:1] <= TRAVEL_W'(TRAVEL_FULL)))
    else $error("travel above full scale");

  // A waiting result holds the sequencer in S_DONE
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && m_valid_q && !m_axis_tready) |=> (state_q == S_DONE))
    else $error("result overwritten while output busy");

  // Divider step counter stays within the quotient width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV1 || state_q == S_DIV2) |-> (cnt_q < 4'(QUO_W)))
    else $error("divider counter out of range");

  // Released key at or above the press level becomes pressed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !key_down_q && (s_sample >= press_q)) |=> key_down_q)
    else $error("press threshold missed");

endmodule

`default_nettype wire

FILE: verif/hkht_checker.sv
// Result checker for the Hall key channel: mirrors registers, predicts key state and travel.
`timescale 1ns / 1ps

module hkht_checker
  import hkht_pkg::*;
#(
  parameter int unsigned SMP_W      = ADC_BITS_DEF,
  parameter int unsigned IN_TDATA_W = ((ADC_BITS_DEF + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Sensor items
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [SMP_W-1:0] sample
  // Result items
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] pressed, [10:1] travel
  // Register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  input  logic                   pready,
  output int unsigned            pending_o,
  output int unsigned            fail_cnt_o
);

  localparam int ADC_MAX = (1 << SMP_W) - 1;

  typedef struct packed {
    logic                pressed;
    logic [TRAVEL_W-1:0] travel;
  } key_report_t;

  key_report_t reports_due[$];

  // Shadow of the register file and the key state
  logic [SMP_W-1:0]    press_q;
  logic [SMP_W-1:0]    release_q;
  logic                cal_q;
  logic [SMP_W-1:0]    rest_q;
  logic [SMP_W-1:0]    full_q;
  logic                inv_q;
  logic [TRAVEL_W-1:0] dlo_q;
  logic [TRAVEL_W-1:0] dhi_q;
  logic                key_q;

  function automatic int clamp_travel(int t);
    if (t < 0) return 0;
    if (t > TRAVEL_FULL) return TRAVEL_FULL;
    return t;
  endfunction

  // Normalized travel for one sample under the current register settings
  function automatic logic [TRAVEL_W-1:0] travel_for(logic [SMP_W-1:0] smp);
    int base;
    int span_top;
    int t;
    int lo;
    int hi;
    int s;
    base     = 0;
    span_top = ADC_MAX;
    s        = smp;
    lo       = dlo_q;
    hi       = dhi_q;
    if (cal_q && rest_q != full_q) begin
      base     = rest_q;
      span_top = full_q;
    end
    // signed division truncates toward zero
    t = ((s - base) * int'(TRAVEL_FULL)) / (span_top - base);
    if (inv_q) t = TRAVEL_FULL - t;
    t = clamp_travel(t);
    // deadzone window only when its upper bound is above the lower one
    if (hi > lo) begin
      if (t <= lo) return '0;
      if (t >= hi) return TRAVEL_W'(TRAVEL_FULL);
      t = ((t - lo) * int'(TRAVEL_FULL)) / (hi - lo);
    end
    return TRAVEL_W'(clamp_travel(t));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    key_report_t      want;
    logic [SMP_W-1:0] smp;
    logic             next_key;
    if (!rst_ni) begin
      press_q   = SMP_W'(PRESS_RESET);
      release_q = SMP_W'(RELEASE_RESET);
      cal_q     = 1'b0;
      rest_q    = '0;
      full_q    = SMP_W'(ADC_MAX);
      inv_q     = 1'b0;
      dlo_q     = '0;
      dhi_q     = '0;
      key_q     = 1'b0;
      reports_due.delete();
      fail_cnt_o = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[APB_ADDR_W-1:2]))
          REG_PRESS_LEVEL:   press_q   = pwdata[SMP_W-1:0];
          REG_RELEASE_LEVEL: release_q = pwdata[SMP_W-1:0];
          REG_CAL_VALID:     cal_q     = pwdata[0];
          REG_REST_READING:  rest_q    = pwdata[SMP_W-1:0];
          REG_FULL_READING:  full_q    = pwdata[SMP_W-1:0];
          REG_INVERT_TRAVEL: inv_q     = pwdata[0];
          REG_DEAD_LOW:      dlo_q     = pwdata[TRAVEL_W-1:0];
          REG_DEAD_HIGH:     dhi_q     = pwdata[TRAVEL_W-1:0];
          default: ;
        endcase
      end

      // compare a result item against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (reports_due.size() == 0) begin
          $error("unexpected result item: pressed %0d travel %0d",
                 m_axis_tdata[0], m_axis_tdata[TRAVEL_W:1]);
          fail_cnt_o++;
        end else begin
          want = reports_due.pop_front();
          if (m_axis_tdata[0] !== want.pressed) begin
            $error("pressed mismatch: expected %0d, actual %0d",
                   want.pressed, m_axis_tdata[0]);
            fail_cnt_o++;
          end
          if (m_axis_tdata[TRAVEL_W:1] !== want.travel) begin
            $error("travel mismatch: expected %0d, actual %0d",
                   want.travel, m_axis_tdata[TRAVEL_W:1]);
            fail_cnt_o++;
          end
        end
      end

      // predict for an accepted sensor item
      if (s_axis_tvalid && s_axis_tready) begin
        smp      = s_axis_tdata[SMP_W-1:0];
        next_key = key_q;
        if (!key_q && smp >= press_q) next_key = 1'b1;
        else if (key_q && smp <= release_q) next_key = 1'b0;
        want.travel  = travel_for(smp);
        want.pressed = next_key;
        key_q        = next_key;
        reports_due.push_back(want);
      end
    end
    pending_o = reports_due.size();
  end

endmodule

FILE: verif/tb_hall_key_hysteresis_and_travel.sv
// Testbench top for the Hall key channel: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_hall_key_hysteresis_and_travel;
  import hkht_pkg::*;

  localparam int unsigned SMP_W       = ADC_BITS_DEF;
  localparam int unsigned IN_TDATA_W  = ((SMP_W + 7) / 8) * 8;
  localparam int          ADC_MAX     = (1 << SMP_W) - 1;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 64;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [11:0] sample
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [0] pressed, [10:1] travel
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  int unsigned pending;
  int unsigned fail_cnt;
  bit          idle_en = 1'b0;
  int unsigned rdy_hold = 0;
  int unsigned quiet_cycles = 0;

  // Current levels, used to aim samples at the interesting points
  int press_cur = PRESS_RESET;
  int release_cur = RELEASE_RESET;
  int rest_cur = 0;
  int full_cur = ADC_MAX;

  hall_key_hysteresis_and_travel u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  hkht_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .pending_o    (pending),
    .fail_cnt_o   (fail_cnt)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result side back-pressure: random low bursts on tready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdy_hold      <= 0;
      m_axis_tready <= 1'b0;
    end else if (rdy_hold != 0) begin
      rdy_hold      <= rdy_hold - 1;
      m_axis_tready <= (rdy_hold == 1);
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      rdy_hold      <= $urandom_range(1, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted item or register write
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One register write: setup then access; caller closes the transfer
  task automatic write_reg(input reg_idx_e idx, input int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic set_config(input int press, input int rel, input int cal, input int rest,
                            input int full, input int inv, input int dlo, input int dhi);
    write_reg(REG_PRESS_LEVEL, press);
    write_reg(REG_RELEASE_LEVEL, rel);
    write_reg(REG_CAL_VALID, cal);
    write_reg(REG_REST_READING, rest);
    write_reg(REG_FULL_READING, full);
    write_reg(REG_INVERT_TRAVEL, inv);
    write_reg(REG_DEAD_LOW, dlo);
    write_reg(REG_DEAD_HIGH, dhi);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    press_cur   = press;
    release_cur = rel;
    rest_cur    = rest;
    full_cur    = full;
  endtask

  // Offer one sample, with an occasional gap ahead of it
  task automatic send_sample(input int smp);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(smp);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Wait until every predicted result has been taken
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mostly uniform, with extra weight near the thresholds and the span ends
  function automatic int pick_sample();
    int v;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) v = $urandom_range(0, ADC_MAX);
    else if (sel < 7) v = press_cur + int'($urandom_range(0, 8)) - 4;
    else if (sel < 9) v = release_cur + int'($urandom_range(0, 8)) - 4;
    else begin
      case ($urandom_range(0, 3))
        0: v = 0;
        1: v = ADC_MAX;
        2: v = rest_cur;
        default: v = full_cur;
      endcase
    end
    if (v < 0) v = 0;
    if (v > ADC_MAX) v = ADC_MAX;
    return v;
  endfunction

  task automatic run_phase(input int unsigned n_items);
    send_sample(0);
    send_sample(ADC_MAX);
    send_sample(press_cur);
    send_sample(release_cur);
    send_sample(rest_cur);
    send_sample(full_cur);
    repeat (n_items) send_sample(pick_sample());
    drain();
  endtask

  task automatic random_config();
    int rest;
    int full;
    int dlo;
    int dhi;
    rest = $urandom_range(0, ADC_MAX);
    full = ($urandom_range(0, 7) == 0) ? rest : $urandom_range(0, ADC_MAX);
    dlo  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 1000);
    dhi  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 1000);
    set_config($urandom_range(0, ADC_MAX), $urandom_range(0, ADC_MAX), $urandom_range(0, 1),
               rest, full, $urandom_range(0, 1), dlo, dhi);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: extremes and the exact hysteresis edges
    idle_en = 1'b1;
    send_sample(0);
    send_sample(ADC_MAX);
    send_sample(PRESS_RESET - 1);
    send_sample(PRESS_RESET);
    send_sample(PRESS_RESET + 1);
    send_sample(RELEASE_RESET + 1);
    send_sample(RELEASE_RESET);
    send_sample(RELEASE_RESET - 1);
    send_sample(RELEASE_RESET);
    send_sample(PRESS_RESET - 1);
    send_sample(2048);
    send_sample(1);
    send_sample(ADC_MAX - 1);
    drain();

    // Calibrated span inside the range, samples beyond it clamp
    set_config(ADC_MAX, 0, 1, 1000, 3000, 0, 100, 900);
    run_phase(54);
    // Release above press, reversed span, inverted travel, full window
    idle_en = 1'b0;
    set_config(0, ADC_MAX, 1, 3000, 1000, 1, 0, 1000);
    run_phase(54);
    // Equal calibration levels fall back to defaults; equal bounds disable the window
    idle_en = 1'b1;
    set_config(2048, 2047, 1, 2048, 2048, 0, 500, 500);
    run_phase(54);
    // Bounds above full scale with an inverted window; calibration off
    set_config(1500, 2500, 0, ADC_MAX, 0, 1, 1023, 1001);
    run_phase(54);
    // One-count span and the narrowest window
    set_config(3000, 1000, 1, 0, 1, 0, 0, 1);
    run_phase(54);
    // Whole span reversed, window upper bound beyond full scale
    set_config(100, 4000, 1, ADC_MAX, 0, 0, 200, 1023);
    run_phase(54);

    // Random settings, some phases without idling
    repeat (6) begin
      idle_en = ($urandom_range(0, 3) != 0);
      random_config();
      run_phase(89);
    end

    // Closing stretch at full rate
    idle_en = 1'b0;
    random_config();
    run_phase(94);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
